[rtl/core/dsf_pkg.sv]
// Shared types and constants for the DLE byte-stuffing framer.
// No dependencies; imported by every module in rtl/core.
package dsf_pkg;

    localparam int MAX_PACKET_BYTES = 256;
    localparam int LEN_FULL         = 2 * MAX_PACKET_BYTES + 3;
    localparam int LEN_CAP          = (LEN_FULL < 1023) ? LEN_FULL : 1023;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 10;
    localparam int ADDR_W = 2;

    localparam logic [BYTE_W-1:0] START_RESET  = 8'h02;
    localparam logic [BYTE_W-1:0] END_RESET    = 8'h03;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h10;

    // register indexes on the configuration port
    localparam logic [ADDR_W-1:0] REG_START  = 2'd0;
    localparam logic [ADDR_W-1:0] REG_END    = 2'd1;
    localparam logic [ADDR_W-1:0] REG_ESCAPE = 2'd2;

    // command codes
    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_CLOSE = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] start_code;
        logic [BYTE_W-1:0] end_code;
        logic [BYTE_W-1:0] escape_code;
    } cfg_t;

    // up to three frame bytes produced by one input transaction
    typedef struct packed {
        logic [2:0][BYTE_W-1:0] bytes;   // bytes[0] goes out first
        logic [1:0]             n;       // number of valid bytes, 1..3
        logic                   close;   // final byte is the end byte
        logic [LEN_W-1:0]       len;     // frame length for the end byte
    } burst_t;

endpackage

[rtl/core/dsf_encoder.sv]
// Frame encoder: holds frame state and builds the byte burst for one input.
// Depends on dsf_pkg.
module dsf_encoder
    import dsf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              in_fire,
    input  logic              cmd,
    input  logic [BYTE_W-1:0] data,
    output burst_t            burst
);

    logic              in_frame_reg, in_frame_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [LEN_W-1:0]  count_reg, count_next;

    logic              special;
    logic [BYTE_W-1:0] sum_base;
    logic [LEN_W-1:0]  count_base;
    logic [LEN_W:0]    count_sum;
    logic [LEN_W-1:0]  count_sat;

    assign special = (data == cfg.start_code) || (data == cfg.escape_code)
                  || (data == cfg.end_code);
    assign sum_base   = in_frame_reg ? sum_reg : '0;
    assign count_base = in_frame_reg ? count_reg : '0;

    always_comb begin
        burst       = '0;
        burst.close = (cmd == CMD_CLOSE);
        if (cmd == CMD_DATA) begin
            if (!in_frame_reg) begin
                if (special) begin
                    burst.bytes = {data, cfg.escape_code, cfg.start_code};
                    burst.n     = 2'd3;
                end else begin
                    burst.bytes = {8'h00, data, cfg.start_code};
                    burst.n     = 2'd2;
                end
            end else begin
                if (special) begin
                    burst.bytes = {8'h00, data, cfg.escape_code};
                    burst.n     = 2'd2;
                end else begin
                    burst.bytes = {8'h00, 8'h00, data};
                    burst.n     = 2'd1;
                end
            end
        end else begin
            if (!in_frame_reg) begin
                burst.bytes = {cfg.end_code, ~sum_base, cfg.start_code};
                burst.n     = 2'd3;
            end else begin
                burst.bytes = {8'h00, cfg.end_code, ~sum_base};
                burst.n     = 2'd2;
            end
        end
        burst.len = count_sat;
    end

    // frame length counts every emitted byte, the end byte included,
    // so one formula serves data and close
    assign count_sum = {1'b0, count_base} + {{(LEN_W-1){1'b0}}, burst.n};
    assign count_sat = (count_sum > LEN_CAP[LEN_W:0]) ? LEN_CAP[LEN_W-1:0]
                                                      : count_sum[LEN_W-1:0];

    always_comb begin
        if (cmd == CMD_DATA) begin
            in_frame_next = 1'b1;
            sum_next      = sum_base + data;
            count_next    = count_sat;
        end else begin
            in_frame_next = 1'b0;
            sum_next      = '0;
            count_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            sum_reg      <= '0;
            count_reg    <= '0;
        end else if (in_fire) begin
            in_frame_reg <= in_frame_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
        end
    end

endmodule

[rtl/core/dsf_burst_buf.sv]
// Burst register and serializer: sends a stored burst one byte per cycle while out_ready is high.
// Depends on dsf_pkg.
module dsf_burst_buf
    import dsf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  burst_t            burst,
    input  logic              load,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              out_last,
    output logic [LEN_W-1:0]  out_len
);

    logic [2:0][BYTE_W-1:0] bytes_reg;
    logic                   close_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [1:0]             rem_reg;
    logic [1:0]             idx_reg;
    logic                   out_fire;

    assign out_valid = (rem_reg != 2'd0);
    assign out_fire  = out_valid && out_ready;
    assign out_byte  = bytes_reg[idx_reg];
    assign out_last  = close_reg && (rem_reg == 2'd1);
    assign out_len   = out_last ? len_reg : '0;
    // free now, or the last byte leaves this cycle
    assign can_load  = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
            idx_reg <= '0;
        end else if (load) begin
            rem_reg <= burst.n;
            idx_reg <= '0;
        end else if (out_fire) begin
            rem_reg <= rem_reg - 2'd1;
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg <= burst.bytes;
            close_reg <= burst.close;
            len_reg   <= burst.len;
        end
    end

endmodule

[rtl/core/dle_stuffing_framer.sv]
// Top level of the DLE byte-stuffing framer: config registers, encoder, burst buffer.
// Depends on dsf_pkg, dsf_encoder and dsf_burst_buf.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+-------------------------------------------
//  s_ (in)  | in  | s_tvalid/s_tready | s_tdata = data_byte, s_tuser = command
//  m_ (out) | out | m_tvalid/m_tready | m_tdata = frame_byte, frame_length; m_tlast
//  cfg_     | in  | cfg_we            | cfg_addr = register index, cfg_wdata
//
// An input transaction yields one to three frame bytes; the output port moves
// one byte per cycle while m_tready is high. The burst register takes a new
// item in the same cycle its last byte is taken, so a run of plain data bytes
// inside an open frame flows at one per cycle while m_tready stays high. Reset
// (aresetn low, synchronous) closes any open frame, empties the burst register
// and restores the default codes. A stall on m_tready holds the current byte
// and backs up into s_tready.
module dle_stuffing_framer
    import dsf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] data_byte
    input  logic              s_tuser,   // [0] command: 0 data, 1 close
    // frame stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // [7:0] frame_byte, [17:8] frame_length, [23:18] zero
    output logic              m_tlast,
    // configuration writes
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [BYTE_W-1:0] cfg_wdata
);

    cfg_t              cfg_reg;
    burst_t            burst;
    logic              s_fire;
    logic              can_load;
    logic [BYTE_W-1:0] frame_byte;
    logic [LEN_W-1:0]  frame_len;

    // code registers; writes to an unused index are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_code  <= START_RESET;
            cfg_reg.end_code    <= END_RESET;
            cfg_reg.escape_code <= ESCAPE_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_START:  cfg_reg.start_code  <= cfg_wdata;
                REG_END:    cfg_reg.end_code    <= cfg_wdata;
                REG_ESCAPE: cfg_reg.escape_code <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_tready = can_load;
    assign s_fire   = s_tvalid && s_tready;

    dsf_encoder u_encoder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .in_fire (s_fire),
        .cmd     (s_tuser),
        .data    (s_tdata),
        .burst   (burst)
    );

    dsf_burst_buf u_burst_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .burst     (burst),
        .load      (s_fire),
        .can_load  (can_load),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (frame_byte),
        .out_last  (m_tlast),
        .out_len   (frame_len)
    );

    assign m_tdata = {6'b0, frame_len, frame_byte};

    // every accepted item produces at least one byte in the next cycle
    a_fire_gives_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_tvalid)
        else $error("accepted item produced no output byte");

    // a new item is taken only when the pending byte is the final one and leaves
    a_ready_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tready && m_tvalid) |-> m_tready)
        else $error("input accepted while burst still pending");

    // the end byte always reports at least sum and end byte
    a_last_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[17:8] >= 10'd2))
        else $error("end byte with impossible frame length");

    // non-final bytes carry no length
    a_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[17:8] == 10'd0))
        else $error("length on a byte that is not the end byte");

endmodule

[sim/dsf_frame_checker.sv]
// Checker for the DLE byte-stuffing framer: watches the input, frame and config ports.
// Predicts every frame byte and compares it in order. Depends on dsf_pkg.
module dsf_frame_checker
    import dsf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] data_byte
    input  logic              s_tuser,   // [0] command
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [23:0]       m_tdata,   // [7:0] frame_byte, [17:8] frame_length, [23:18] zero
    input  logic              m_tlast,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [BYTE_W-1:0] cfg_wdata,
    input  logic              final_check,
    output int                fail_count,
    output int                expected_left
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              last;
        logic [LEN_W-1:0]  frame_length;
    } frame_entry_t;

    frame_entry_t      frame_q[$];
    cfg_t              codes;
    logic              frame_open;
    logic [BYTE_W-1:0] data_sum;
    logic [LEN_W-1:0]  frame_count;

    task automatic report_mismatch(input string what);
        $display("[%0t] frame check: %s", $time, what);
        fail_count++;
    endtask

    // queue one frame byte; the length saturates and only rides on the end byte
    task automatic expect_byte(input logic [BYTE_W-1:0] value, input logic is_end);
        frame_entry_t entry;
        if (frame_count < LEN_CAP)
            frame_count++;
        entry.frame_byte   = value;
        entry.last         = is_end;
        entry.frame_length = is_end ? frame_count : '0;
        frame_q.push_back(entry);
    endtask

    task automatic encode_item(input logic cmd, input logic [BYTE_W-1:0] value);
        if (!frame_open) begin
            frame_open  = 1'b1;
            data_sum    = '0;
            frame_count = '0;
            expect_byte(codes.start_code, 1'b0);
        end
        if (cmd == CMD_DATA) begin
            if (value == codes.start_code || value == codes.escape_code ||
                value == codes.end_code)
                expect_byte(codes.escape_code, 1'b0);
            expect_byte(value, 1'b0);
            data_sum = data_sum + value;
        end else begin
            expect_byte(~data_sum, 1'b0);   // checksum byte is never escaped
            expect_byte(codes.end_code, 1'b1);
            frame_open  = 1'b0;
            data_sum    = '0;
            frame_count = '0;
        end
    endtask

    always @(posedge aclk) begin
        frame_entry_t want;
        if (!aresetn) begin
            codes       = '{START_RESET, END_RESET, ESCAPE_RESET};
            frame_open  = 1'b0;
            data_sum    = '0;
            frame_count = '0;
            fail_count  = 0;
            frame_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_START:  codes.start_code  = cfg_wdata;
                    REG_END:    codes.end_code    = cfg_wdata;
                    REG_ESCAPE: codes.escape_code = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                encode_item(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (frame_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected frame byte %02h", m_tdata[7:0]));
                end else begin
                    want = frame_q.pop_front();
                    if (m_tdata[7:0] !== want.frame_byte)
                        report_mismatch($sformatf("frame_byte %02h, expected %02h",
                                                  m_tdata[7:0], want.frame_byte));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("tlast %b, expected %b",
                                                  m_tlast, want.last));
                    if (m_tdata[17:8] !== want.frame_length)
                        report_mismatch($sformatf("frame_length %0d, expected %0d",
                                                  m_tdata[17:8], want.frame_length));
                end
            end
            if (final_check && frame_q.size() != 0)
                report_mismatch($sformatf("%0d frame bytes never arrived", frame_q.size()));
        end
        expected_left = frame_q.size();
    end

endmodule

[sim/tb_dle_stuffing_framer.sv]
// Testbench top for dle_stuffing_framer: clock, reset, stimulus and the verdict.
// Depends on dsf_pkg, dle_stuffing_framer and dsf_frame_checker.
module tb_dle_stuffing_framer;
    timeunit 1ns;
    timeprecision 1ps;
    import dsf_pkg::*;

    // write to an index past the register list; the block must ignore it
    localparam logic [ADDR_W-1:0] REG_UNUSED = 2'd3;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;   // [7:0] data_byte
    logic              s_tuser;   // [0] command
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [23:0]       m_tdata;   // [7:0] frame_byte, [17:8] frame_length, [23:18] zero
    logic              m_tlast;
    logic              cfg_we;
    logic [ADDR_W-1:0] cfg_addr;
    logic [BYTE_W-1:0] cfg_wdata;
    logic              final_check;
    int                fail_count;
    int                expected_left;

    // idle rates in percent, per side
    int                send_idle_pct;
    int                recv_idle_pct;
    // our copy of the codes, used only to aim random data at the special values
    logic [BYTE_W-1:0] cur_start;
    logic [BYTE_W-1:0] cur_end;
    logic [BYTE_W-1:0] cur_esc;

    dle_stuffing_framer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    dsf_frame_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .final_check   (final_check),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    always #5 aclk = ~aclk;

    // receiver: tready re-rolled every cycle at the falling edge
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // One input transaction. Returns at the falling edge after acceptance with
    // tvalid still high; whoever goes next either re-drives it or drops it.
    task automatic send_item(input logic cmd, input logic [7:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // stop sending and let every outstanding frame byte drain out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (expected_left != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // call only with the block drained
    task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [BYTE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
        case (idx)
            REG_START:  cur_start = value;
            REG_END:    cur_end   = value;
            REG_ESCAPE: cur_esc   = value;
            default: ;
        endcase
    endtask

    task automatic write_codes(input logic [7:0] st, input logic [7:0] en, input logic [7:0] es);
        write_reg(REG_START, st);
        write_reg(REG_END, en);
        write_reg(REG_ESCAPE, es);
    endtask

    // random byte, biased toward the three special codes so stuffing gets exercised
    function automatic logic [7:0] pick_byte(input int special_pct);
        if ($urandom_range(99) >= special_pct)
            return 8'($urandom);
        case ($urandom_range(2))
            0:       return cur_start;
            1:       return cur_end;
            default: return cur_esc;
        endcase
    endfunction

    // whole packet: n data bytes then close (close carries a random, ignored byte)
    task automatic send_packet(input int n, input int special_pct);
        for (int i = 0; i < n; i++)
            send_item(CMD_DATA, pick_byte(special_pct));
        send_item(CMD_CLOSE, 8'($urandom));
    endtask

    // mostly short packets, some empty, with an occasional full drain in between
    task automatic run_phase(input int sidle, input int ridle, input int n_items);
        int sent;
        int n;
        sent          = 0;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        while (sent < n_items) begin
            n = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 8);
            send_packet(n, 25);
            sent += n + 1;
            if ($urandom_range(5) == 0)
                wait_drained();
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = CMD_DATA;
        cfg_we        = 1'b0;
        cfg_addr      = REG_START;
        cfg_wdata     = '0;
        final_check   = 1'b0;
        send_idle_pct = 10;
        recv_idle_pct = 10;
        cur_start     = START_RESET;
        cur_end       = END_RESET;
        cur_esc       = ESCAPE_RESET;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ---- directed part, default codes ----
        // empty packet: start, 0xFF checksum, end with length 3
        send_item(CMD_CLOSE, 8'h00);
        // byte extremes plus each special code; only the special codes get escaped
        send_item(CMD_DATA, 8'h00);
        send_item(CMD_DATA, 8'hFF);
        send_item(CMD_DATA, START_RESET);
        send_item(CMD_DATA, END_RESET);
        send_item(CMD_DATA, ESCAPE_RESET);
        send_item(CMD_DATA, 8'hA5);
        send_item(CMD_DATA, 8'h5A);
        send_item(CMD_CLOSE, 8'hFF);

        // code change while a frame is open: applies from the next byte on
        send_item(CMD_DATA, 8'h41);
        wait_drained();
        write_reg(REG_START, 8'h41);
        send_item(CMD_DATA, 8'h41);
        send_item(CMD_CLOSE, 8'h00);

        // out-of-range index is dropped; then all three codes equal
        wait_drained();
        write_reg(REG_UNUSED, 8'h7D);
        write_codes(8'h7E, 8'h7E, 8'h7E);
        send_item(CMD_DATA, 8'h7E);
        send_item(CMD_DATA, 8'h7D);
        send_item(CMD_CLOSE, 8'h00);
        send_item(CMD_CLOSE, 8'h00);

        // ---- random part ----
        // phase 1: slow receiver, code extremes
        wait_drained();
        write_codes(8'h00, 8'hFF, 8'h80);
        run_phase(36, 62, 30);

        // phase 2: slow sender, reversed extremes
        wait_drained();
        write_codes(8'hFF, 8'h00, 8'($urandom));
        run_phase(62, 36, 30);

        // phase 3: no idling, random codes
        wait_drained();
        write_codes(8'($urandom), 8'($urandom), 8'($urandom));
        run_phase(0, 0, 25);

        // ---- wind down ----
        wait_drained();
        repeat (8) @(negedge aclk);
        final_check <= 1'b1;
        @(negedge aclk);
        final_check <= 1'b0;
        @(negedge aclk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[dle_stuffing_framer.f]
rtl/core/dsf_pkg.sv
rtl/core/dsf_encoder.sv
rtl/core/dsf_burst_buf.sv
rtl/core/dle_stuffing_framer.sv
sim/dsf_frame_checker.sv
sim/tb_dle_stuffing_framer.sv
